FILE: hw/rtl/slot_allocator_reuse_delay_top_defines.svh
// ---------------------------------------------------------------------------
// slot allocator assertion macros
// shared assertion wrappers, compiled out when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef SLOT_ALLOCATOR_REUSE_DELAY_TOP_DEFINES_SVH
`define SLOT_ALLOCATOR_REUSE_DELAY_TOP_DEFINES_SVH

`ifndef SYNTH
// checked only outside reset
`define SARD_ASSERT(name, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("sard assertion failed");
// checked at every edge, reset included
`define SARD_ASSERT_ALWAYS(name, prop) \
    name: assert property (@(posedge aclk) prop) \
        else $error("sard assertion failed");
`else
`define SARD_ASSERT(name, prop)
`define SARD_ASSERT_ALWAYS(name, prop)
`endif

`endif

FILE: hw/rtl/sard_pkg.sv
// ---------------------------------------------------------------------------
// sard_pkg
// types and constants shared by the slot allocator modules
// ---------------------------------------------------------------------------
package sard_pkg;

    // item field widths
    localparam int FUNC_W      = 2;
    localparam int SLOT_IDX_W  = 11;
    localparam int TIME_W      = 31;
    localparam int STATUS_W    = 2;
    localparam int SLOT_OUT_W  = 10;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 16;

    // configuration port
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_REUSE_DELAY   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_GRACE = 1'd1;
    localparam logic [CFG_DATA_W-1:0] DEFAULT_REUSE_DELAY   = 16'd1000;
    localparam logic [CFG_DATA_W-1:0] DEFAULT_STARTUP_GRACE = 16'd2000;

    // item functions
    localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FN_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_FRAME = 2'd2;
    localparam logic [FUNC_W-1:0] FN_LEVEL = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_SLOT   = 2'd2;

    // one slot table entry
    typedef struct packed {
        logic              in_use;
        logic [TIME_W-1:0] freed_at;
    } sard_entry_t;

    localparam int ENTRY_W = $bits(sard_entry_t);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP,
        S_THR,
        S_SCAN,
        S_RD,
        S_WR,
        S_DONE
    } sard_state_t;

endpackage

FILE: hw/rtl/sard_ram.sv
// ---------------------------------------------------------------------------
// sard_ram
// generic simple dual-port ram, one write port, registered read
// ---------------------------------------------------------------------------
module sard_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/sard_slot_check.sv
// ---------------------------------------------------------------------------
// sard_slot_check
// shared compare unit: decides whether one table entry may be handed out
// ---------------------------------------------------------------------------
module sard_slot_check (
    input  sard_pkg::sard_entry_t entry_i,
    input  logic [31:0]           thr_i,
    input  logic                  force_i,
    output logic                  qualify_o
);
    import sard_pkg::*;

    logic resting;

    // resting when freed after both the grace end and now minus the delay
    assign resting   = ({1'b0, entry_i.freed_at} > thr_i);
    assign qualify_o = !entry_i.in_use && (force_i || !resting);

endmodule

FILE: hw/rtl/slot_allocator_reuse_delay_top.sv
// ---------------------------------------------------------------------------
// slot_allocator_reuse_delay_top
// slot allocator over a fixed table with a reuse quarantine on freed slots
// ---------------------------------------------------------------------------
// One item at a time. Free, frame and bad-index items go from IDLE straight
// to DONE, an explicit allocate passes through RD and WR first. A general
// allocate computes its quarantine threshold in PREP and THR, then walks the
// table through the ram's single read port at one slot per cycle from
// RESERVED_SLOTS up to the high-water mark, and after the last registered
// read closes the pass; a miss that grows the mark adds a read-modify-write
// through RD and WR, and a miss at the limit runs a second, forced walk.
// A level-start item and reset both run a clearing pass that writes every
// entry of the table, one per cycle; no item is taken meanwhile,
// configuration writes are. Each item gives one result item, held in an
// output register, so the block can start the next item while a result
// waits to be taken.
// ---------------------------------------------------------------------------
`include "slot_allocator_reuse_delay_top_defines.svh"

module slot_allocator_reuse_delay_top #(
    parameter int TABLE_SLOTS    = 1024,
    parameter int RESERVED_SLOTS = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [sard_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sard_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input items
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sard_pkg::S_TDATA_W-1:0]   s_tdata,  // func, slot_index, time_ms
    // result items
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sard_pkg::M_TDATA_W-1:0]   m_tdata   // status, slot_out
);
    import sard_pkg::*;

    // table index and counter widths
    localparam int IDX_W      = $clog2(TABLE_SLOTS);
    localparam int SPAN       = (TABLE_SLOTS > RESERVED_SLOTS) ? TABLE_SLOTS : RESERVED_SLOTS;
    localparam int CNT_W      = $clog2(SPAN + 1);
    localparam int WORLD_SLOT = TABLE_SLOTS - 2;
    localparam int GROW_LIMIT = TABLE_SLOTS - 2;
    localparam int HW_MAX     = (GROW_LIMIT > RESERVED_SLOTS) ? GROW_LIMIT : RESERVED_SLOTS;

    // input item fields
    logic [FUNC_W-1:0]     in_func;
    logic [SLOT_IDX_W-1:0] in_idx;
    logic [TIME_W-1:0]     in_time;
    logic                  s_accept;
    logic                  alloc_ok;
    logic                  free_ok;

    assign in_func  = s_tdata[1:0];
    assign in_idx   = s_tdata[12:2];
    assign in_time  = s_tdata[43:13];
    assign s_accept = s_tvalid && s_tready;

    // explicit index checks (alloc_ok leaves the sign bit to its use, free_ok tests it)
    assign alloc_ok = ((32'(in_idx[9:0]) < 32'(RESERVED_SLOTS)) ||
                       (32'(in_idx[9:0]) == 32'(WORLD_SLOT))) &&
                      (32'(in_idx[9:0]) < 32'(TABLE_SLOTS));
    assign free_ok  = !in_idx[10] && (32'(in_idx[9:0]) < 32'(TABLE_SLOTS));

    // sequencer and datapath registers
    sard_state_t             state_reg, state_next;
    logic [CNT_W-1:0]        addr_reg, addr_next;       // scan / clear pointer
    logic [CNT_W-1:0]        hw_reg, hw_next;           // high-water mark
    logic [CNT_W-1:0]        top_reg, top_next;         // scan end
    logic [IDX_W-1:0]        target_reg, target_next;   // read-modify-write slot
    logic [IDX_W-1:0]        pend_addr_reg, pend_addr_next;
    logic                    pend_v_reg, pend_v_next;   // read in flight
    logic                    force_reg, force_next;     // forced scan pass
    logic                    clr_item_reg, clr_item_next;
    logic [TIME_W-1:0]       now_reg, now_next;
    logic [TIME_W-1:0]       ls_reg, ls_next;           // level start time
    logic [CFG_DATA_W-1:0]   delay_reg, delay_next;
    logic [CFG_DATA_W-1:0]   grace_reg, grace_next;
    logic [31:0]             ge_reg, ge_next;           // grace end
    logic signed [32:0]      nd_reg, nd_next;           // now minus delay
    logic [31:0]             thr_reg, thr_next;         // quarantine threshold
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [SLOT_OUT_W-1:0]   slot_reg, slot_next;
    logic                    m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]    m_data_reg, m_data_next;

    // table memory
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    sard_entry_t             ram_wentry;
    logic [IDX_W-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]      ram_rdata;
    sard_entry_t             ram_rentry;
    logic                    qualify;
    logic                    issue;

    assign ram_rentry = ram_rdata;

    sard_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_table (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared compare unit, one entry per cycle
    sard_slot_check u_check (
        .entry_i   (ram_rentry),
        .thr_i     (thr_reg),
        .force_i   (force_reg),
        .qualify_o (qualify)
    );

    // another slot left to read in this pass
    assign issue = (addr_reg < top_reg);

    always_comb begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        hw_next        = hw_reg;
        top_next       = top_reg;
        target_next    = target_reg;
        pend_addr_next = pend_addr_reg;
        pend_v_next    = pend_v_reg;
        force_next     = force_reg;
        clr_item_next  = clr_item_reg;
        now_next       = now_reg;
        ls_next        = ls_reg;
        delay_next     = delay_reg;
        grace_next     = grace_reg;
        ge_next        = ge_reg;
        nd_next        = nd_reg;
        thr_next       = thr_reg;
        status_next    = status_reg;
        slot_next      = slot_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = addr_reg[IDX_W-1:0];
        ram_wentry     = '0;
        ram_raddr      = addr_reg[IDX_W-1:0];

        // result taken downstream
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        // configuration writes, taken in any state
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_REUSE_DELAY:   delay_next = cfg_wdata;
                CFG_STARTUP_GRACE: grace_next = cfg_wdata;
                default:           ;
            endcase
        end

        case (state_reg)
            S_CLEAR: begin
                // zero one entry per cycle
                ram_we     = 1'b1;
                ram_waddr  = addr_reg[IDX_W-1:0];
                ram_wentry = '0;
                if (addr_reg == CNT_W'(TABLE_SLOTS - 1)) begin
                    state_next = clr_item_reg ? S_DONE : S_IDLE;
                end else begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    status_next = STAT_OK;
                    slot_next   = '0;
                    state_next  = S_DONE;
                    case (in_func)
                        FN_ALLOC: begin
                            if (in_idx[10]) begin
                                // any free slot: general scan
                                state_next = S_PREP;
                            end else if (alloc_ok) begin
                                target_next = IDX_W'(in_idx[9:0]);
                                slot_next   = in_idx[9:0];
                                state_next  = S_RD;
                            end else begin
                                status_next = STAT_BAD_INDEX;
                            end
                        end
                        FN_FREE: begin
                            if (free_ok) begin
                                ram_we     = 1'b1;
                                ram_waddr  = IDX_W'(in_idx[9:0]);
                                ram_wentry = '{in_use: 1'b0, freed_at: now_reg};
                            end else begin
                                status_next = STAT_BAD_INDEX;
                            end
                        end
                        FN_FRAME: begin
                            now_next = in_time;
                        end
                        FN_LEVEL: begin
                            now_next      = in_time;
                            ls_next       = in_time;
                            hw_next       = CNT_W'(RESERVED_SLOTS);
                            addr_next     = '0;
                            clr_item_next = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            S_PREP: begin
                ge_next  = {1'b0, ls_reg} + {16'd0, grace_reg};
                nd_next  = $signed({2'b00, now_reg}) - $signed({17'd0, delay_reg});
                top_next = (hw_reg < CNT_W'(TABLE_SLOTS)) ? hw_reg : CNT_W'(TABLE_SLOTS);
                state_next = S_THR;
            end
            S_THR: begin
                // resting iff freed_at is above both bounds
                thr_next    = (nd_reg > $signed({1'b0, ge_reg})) ? nd_reg[31:0] : ge_reg;
                addr_next   = CNT_W'(RESERVED_SLOTS);
                pend_v_next = 1'b0;
                force_next  = 1'b0;
                state_next  = S_SCAN;
            end
            S_SCAN: begin
                if (pend_v_reg && qualify) begin
                    // hit: mark in use, keep the stamp
                    ram_we      = 1'b1;
                    ram_waddr   = pend_addr_reg;
                    ram_wentry  = '{in_use: 1'b1, freed_at: ram_rentry.freed_at};
                    slot_next   = SLOT_OUT_W'(pend_addr_reg);
                    pend_v_next = 1'b0;
                    state_next  = S_DONE;
                end else if (!pend_v_reg && !issue) begin
                    // pass exhausted
                    if (!force_reg && (hw_reg < CNT_W'(GROW_LIMIT))) begin
                        target_next = IDX_W'(hw_reg);
                        slot_next   = SLOT_OUT_W'(hw_reg);
                        hw_next     = hw_reg + 1'b1;
                        state_next  = S_RD;
                    end else if (!force_reg) begin
                        force_next = 1'b1;
                        addr_next  = CNT_W'(RESERVED_SLOTS);
                    end else begin
                        status_next = STAT_NO_SLOT;
                        slot_next   = '0;
                        state_next  = S_DONE;
                    end
                end else begin
                    pend_v_next    = issue;
                    pend_addr_next = addr_reg[IDX_W-1:0];
                    if (issue) begin
                        addr_next = addr_reg + 1'b1;
                    end
                end
            end
            S_RD: begin
                ram_raddr  = target_reg;
                state_next = S_WR;
            end
            S_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = target_reg;
                ram_wentry = '{in_use: 1'b1, freed_at: ram_rentry.freed_at};
                state_next = S_DONE;
            end
            S_DONE: begin
                // load the output register once it is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_data_next   = {4'd0, slot_reg, status_reg};
                    clr_item_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            addr_reg     <= '0;
            hw_reg       <= CNT_W'(RESERVED_SLOTS);
            pend_v_reg   <= 1'b0;
            force_reg    <= 1'b0;
            clr_item_reg <= 1'b0;
            now_reg      <= '0;
            ls_reg       <= '0;
            delay_reg    <= DEFAULT_REUSE_DELAY;
            grace_reg    <= DEFAULT_STARTUP_GRACE;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            hw_reg       <= hw_next;
            pend_v_reg   <= pend_v_next;
            force_reg    <= force_next;
            clr_item_reg <= clr_item_next;
            now_reg      <= now_next;
            ls_reg       <= ls_next;
            delay_reg    <= delay_next;
            grace_reg    <= grace_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        top_reg       <= top_next;
        target_reg    <= target_next;
        pend_addr_reg <= pend_addr_next;
        ge_reg        <= ge_next;
        nd_reg        <= nd_next;
        thr_reg       <= thr_next;
        status_reg    <= status_next;
        slot_reg      <= slot_next;
        m_data_reg    <= m_data_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // no table write while the threshold is set up or a result is handed off
    `SARD_ASSERT(a_no_write_outside_work, (state_reg == S_PREP || state_reg == S_THR || state_reg == S_DONE) |-> !ram_we)
    // the high-water mark never passes its limit once reset has loaded it
    `SARD_ASSERT_ALWAYS(a_hw_bounded, !aresetn || (hw_reg <= CNT_W'(HW_MAX)))
    // a frame item sets the time and goes straight to its result
    `SARD_ASSERT(a_frame_time, (s_accept && in_func == FN_FRAME) |=> (now_reg == $past(in_time) && state_reg == S_DONE))

endmodule

FILE: sim/slot_table_checker.sv
// ---------------------------------------------------------------------------
// slot_table_checker
// watches the slot allocator's channels, keeps its own copy of the slot
// table and the time registers, and compares each result item field by
// field with the answer worked out from the accepted input items
// ---------------------------------------------------------------------------
module slot_table_checker #(
    parameter int TABLE_SLOTS    = 1024,
    parameter int RESERVED_SLOTS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [sard_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sard_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [sard_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [sard_pkg::M_TDATA_W-1:0]  m_tdata,
    output int                              mismatches,
    output int                              answers_owed
);
    import sard_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORLD_SLOT = TABLE_SLOTS - 2;
    localparam int GROW_LIMIT = TABLE_SLOTS - 2;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_OUT_W-1:0] slot;
    } answer_t;

    // table copy
    bit                slot_busy     [TABLE_SLOTS];
    logic [TIME_W-1:0] slot_freed_ms [TABLE_SLOTS];
    int                open_top;
    logic [TIME_W-1:0] clock_ms;
    logic [TIME_W-1:0] level_ms;
    logic [CFG_DATA_W-1:0] rest_ms;
    logic [CFG_DATA_W-1:0] grace_ms;

    answer_t answers_due [$];

    // freed after the grace window and not yet rested long enough
    function automatic bit resting(int s);
        longint freed;
        longint now_l;
        longint fence;
        longint rest;
        freed = longint'(slot_freed_ms[s]);
        now_l = longint'(clock_ms);
        fence = longint'(level_ms) + longint'(grace_ms);
        rest  = longint'(rest_ms);
        if (freed <= fence)
            return 1'b0;
        return (now_l - freed) < rest;
    endfunction

    function automatic int find_slot(bit forced);
        int top;
        top = (open_top < TABLE_SLOTS) ? open_top : TABLE_SLOTS;
        for (int s = RESERVED_SLOTS; s < top; s++) begin
            if (!slot_busy[s] && (forced || !resting(s)))
                return s;
        end
        return -1;
    endfunction

    task automatic clear_table();
        for (int s = 0; s < TABLE_SLOTS; s++) begin
            slot_busy[s]     = 1'b0;
            slot_freed_ms[s] = '0;
        end
        open_top = RESERVED_SLOTS;
    endtask

    task automatic apply_request(input logic [S_TDATA_W-1:0] word);
        logic [FUNC_W-1:0]            fn;
        logic signed [SLOT_IDX_W-1:0] raw;
        logic [TIME_W-1:0]            tm;
        int                           idx;
        int                           s;
        answer_t                      ans;
        fn  = word[FUNC_W-1:0];
        raw = word[FUNC_W +: SLOT_IDX_W];
        tm  = word[FUNC_W+SLOT_IDX_W +: TIME_W];
        idx = raw;
        ans.status = STAT_OK;
        ans.slot   = '0;
        case (fn)
            FN_ALLOC: begin
                if (idx >= 0) begin
                    if ((idx < RESERVED_SLOTS || idx == WORLD_SLOT) && idx < TABLE_SLOTS) begin
                        slot_busy[idx] = 1'b1;
                        ans.slot = SLOT_OUT_W'(idx);
                    end else begin
                        ans.status = STAT_BAD_INDEX;
                    end
                end else begin
                    s = find_slot(1'b0);
                    if (s < 0 && open_top < GROW_LIMIT) begin
                        s = open_top;
                        open_top++;
                    end else if (s < 0) begin
                        s = find_slot(1'b1);
                    end
                    if (s >= 0) begin
                        slot_busy[s] = 1'b1;
                        ans.slot = SLOT_OUT_W'(s);
                    end else begin
                        ans.status = STAT_NO_SLOT;
                    end
                end
            end
            FN_FREE: begin
                if (idx >= 0 && idx < TABLE_SLOTS) begin
                    slot_busy[idx]     = 1'b0;
                    slot_freed_ms[idx] = clock_ms;
                end else begin
                    ans.status = STAT_BAD_INDEX;
                end
            end
            FN_FRAME: begin
                clock_ms = tm;
            end
            FN_LEVEL: begin
                clock_ms = tm;
                level_ms = tm;
                clear_table();
            end
            default: ;
        endcase
        answers_due.push_back(ans);
    endtask

    always @(posedge aclk) begin
        answer_t got;
        answer_t want;
        if (!aresetn) begin
            clear_table();
            clock_ms   = '0;
            level_ms   = '0;
            rest_ms    = DEFAULT_REUSE_DELAY;
            grace_ms   = DEFAULT_STARTUP_GRACE;
            mismatches = 0;
            answers_due.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_REUSE_DELAY:   rest_ms  = cfg_wdata;
                    CFG_STARTUP_GRACE: grace_ms = cfg_wdata;
                    default: ;
                endcase
            end
            // results first, so an item taken at this edge cannot match itself
            if (m_tvalid && m_tready) begin
                got.status = m_tdata[STATUS_W-1:0];
                got.slot   = m_tdata[STATUS_W +: SLOT_OUT_W];
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected result item, got status %0d slot %0d",
                             $time, got.status, got.slot);
                    mismatches++;
                end else begin
                    want = answers_due.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, got.status);
                        mismatches++;
                    end
                    if (got.slot !== want.slot) begin
                        $display("%0t: slot_out mismatch, expected %0d, got %0d",
                                 $time, want.slot, got.slot);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                apply_request(s_tdata);
        end
        answers_owed = answers_due.size();
    end

endmodule

FILE: sim/slot_allocator_reuse_delay_top_tb.sv
// ---------------------------------------------------------------------------
// slot_allocator_reuse_delay_top_tb
// drives the slot allocator with directed and random items under random
// idling on both channels; a checker beside the block predicts and compares
// ---------------------------------------------------------------------------
module slot_allocator_reuse_delay_top_tb;
    import sard_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SLOTS    = 1024;
    localparam int RESERVED_SLOTS = 64;
    localparam int WORLD_SLOT     = TABLE_SLOTS - 2;
    // slot index that asks for any free slot
    localparam int ANY_SLOT       = -1;
    // cycles with no item taken on either side before the run is given up
    localparam int STALL_LIMIT    = 40000;
    // a forced scan at the limit walks the table twice
    localparam int SETTLE_CYCLES  = 2 * TABLE_SLOTS + 64;
    localparam int PHASE_ITEMS    = 139;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // func, slot_index, time_ms
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;   // status, slot_out

    int mismatches;
    int answers_owed;

    // idling state of each side: a run of items either with or without gaps
    int tx_run  = 0;
    bit tx_busy = 1'b0;
    int rx_run  = 0;
    bit rx_busy = 1'b0;
    int rx_gap  = 0;
    bit rx_took = 1'b0;

    // time the stimulus believes the block is at
    logic [TIME_W-1:0] cur_ms;

    slot_allocator_reuse_delay_top #(
        .TABLE_SLOTS    (TABLE_SLOTS),
        .RESERVED_SLOTS (RESERVED_SLOTS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    slot_table_checker #(
        .TABLE_SLOTS    (TABLE_SLOTS),
        .RESERVED_SLOTS (RESERVED_SLOTS)
    ) u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .mismatches   (mismatches),
        .answers_owed (answers_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // gap before the next item; every so often switch between a stretch
    // with random gaps and one with none at all
    function automatic int pick_gap(inout int run, inout bit busy);
        if (run == 0) begin
            busy = ($urandom_range(0, 2) == 0);
            run  = $urandom_range(10, 60);
        end
        run--;
        return busy ? 0 : $urandom_range(0, 16);
    endfunction

    // receiver: note each taken result item at the rising edge
    always @(posedge aclk) begin
        rx_took <= m_tvalid && m_tready;
    end

    // receiver: after each result item draw a stall and hold tready low for it
    always @(negedge aclk) begin
        int gap;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap = rx_gap - 1;
            m_tready <= 1'b0;
        end else if (m_tready && rx_took) begin
            gap = pick_gap(rx_run, rx_busy);
            if (gap > 0) begin
                m_tready <= 1'b0;
                rx_gap = gap - 1;
            end
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog: give up when nothing moves on either channel for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("slot_allocator_reuse_delay_top_tb: FAIL");
        $finish;
    end

    // register write, one cycle long; entered and left at a falling edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // one input item; entered and left at a falling edge, valid stays high
    // so the next item can follow with no gap
    task automatic send_item(input logic [FUNC_W-1:0] fn, input int idx,
                             input logic [TIME_W-1:0] tm);
        int                   gap;
        logic [S_TDATA_W-1:0] word;
        gap  = pick_gap(tx_run, tx_busy);
        word = '0;
        word[FUNC_W-1:0]                = fn;
        word[FUNC_W +: SLOT_IDX_W]      = idx[SLOT_IDX_W-1:0];
        word[FUNC_W+SLOT_IDX_W +: TIME_W] = tm;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= word;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // hold the sender off until every result item owed has been taken
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (answers_owed != 0);
    endtask

    // one random item; general allocates and frees near the low end of the
    // open range dominate so the quarantine and reuse paths stay busy
    task automatic send_random_item();
        int pick;
        int sel;
        int idx;
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 9);
        if (pick < 36) begin
            // general allocate, now and then with some other negative index
            idx = (sel == 0) ? -int'($urandom_range(1, 1024)) : ANY_SLOT;
            send_item(FN_ALLOC, idx, TIME_W'($urandom));
        end else if (pick < 60) begin
            if (sel < 6)
                idx = $urandom_range(RESERVED_SLOTS, RESERVED_SLOTS + 40);
            else if (sel < 8)
                idx = $urandom_range(0, TABLE_SLOTS - 1);
            else if (sel == 8)
                idx = $urandom_range(0, RESERVED_SLOTS - 1);
            else
                idx = -int'($urandom_range(1, 1024));
            send_item(FN_FREE, idx, TIME_W'($urandom));
        end else if (pick < 70) begin
            // explicit allocate: reserved, world, or an index past the reserved range, mostly refused
            if (sel < 5)
                idx = $urandom_range(0, RESERVED_SLOTS - 1);
            else if (sel < 7)
                idx = WORLD_SLOT;
            else
                idx = $urandom_range(RESERVED_SLOTS, TABLE_SLOTS - 1);
            send_item(FN_ALLOC, idx, TIME_W'($urandom));
        end else if (pick < 94) begin
            // mostly small steps forward, sometimes a jump anywhere
            if ($urandom_range(0, 15) == 0)
                cur_ms = TIME_W'($urandom);
            else
                cur_ms = cur_ms + TIME_W'($urandom_range(0, 1500));
            send_item(FN_FRAME, $urandom_range(0, 2047), cur_ms);
        end else begin
            cur_ms = cur_ms + TIME_W'($urandom_range(0, 3000));
            send_item(FN_LEVEL, $urandom_range(0, 2047), cur_ms);
        end
    endtask

    initial begin
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cur_ms    = '0;
        aresetn   = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: default timing, taken while the reset clear runs
        write_reg(CFG_REUSE_DELAY, 16'd1000);
        write_reg(CFG_STARTUP_GRACE, 16'd2000);

        // explicit allocates: reserved ends, world slot, refused indexes
        send_item(FN_ALLOC, 0, '0);
        send_item(FN_ALLOC, RESERVED_SLOTS - 1, '0);
        send_item(FN_ALLOC, WORLD_SLOT, '0);
        send_item(FN_ALLOC, RESERVED_SLOTS, '0);
        send_item(FN_ALLOC, TABLE_SLOTS - 1, '0);
        // general allocates open the first two slots past the reserved ones
        send_item(FN_ALLOC, ANY_SLOT, '0);
        send_item(FN_ALLOC, -1024, '0);
        // freed inside the start-up grace window: reused at once
        send_item(FN_FREE, RESERVED_SLOTS, '0);
        send_item(FN_ALLOC, ANY_SLOT, '0);
        // freed after the grace window: skipped, the mark grows instead
        send_item(FN_FRAME, 0, 31'd5000);
        send_item(FN_FREE, RESERVED_SLOTS + 1, '0);
        send_item(FN_ALLOC, ANY_SLOT, '0);
        // exactly the reuse delay later the slot is back
        send_item(FN_FRAME, 0, 31'd6000);
        send_item(FN_ALLOC, ANY_SLOT, '0);
        // bad and edge free indexes
        send_item(FN_FREE, ANY_SLOT, '0);
        send_item(FN_FREE, -1024, '0);
        send_item(FN_FREE, TABLE_SLOTS - 1, '0);
        send_item(FN_FREE, 0, '0);
        // time running backwards counts as inside the delay
        send_item(FN_FRAME, 0, 31'h7FFF_FFFF);
        send_item(FN_FREE, RESERVED_SLOTS + 2, '0);
        send_item(FN_FRAME, 0, 31'd100);
        send_item(FN_ALLOC, ANY_SLOT, 31'h7FFF_FFFF);
        // level start clears the table and the mark
        send_item(FN_LEVEL, 0, 31'd3000);
        send_item(FN_ALLOC, ANY_SLOT, '0);
        cur_ms = 31'd3000;
        drain();

        // random phases, each under its own timing, extremes first
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_REUSE_DELAY, 16'd0);
                    write_reg(CFG_STARTUP_GRACE, 16'd0);
                end
                1: begin
                    write_reg(CFG_REUSE_DELAY, 16'hFFFF);
                    write_reg(CFG_STARTUP_GRACE, 16'hFFFF);
                end
                2: begin
                    write_reg(CFG_REUSE_DELAY, CFG_DATA_W'($urandom));
                    write_reg(CFG_STARTUP_GRACE, CFG_DATA_W'($urandom));
                end
                default: begin
                    write_reg(CFG_REUSE_DELAY, CFG_DATA_W'($urandom_range(200, 1500)));
                    write_reg(CFG_STARTUP_GRACE, CFG_DATA_W'($urandom_range(0, 3000)));
                end
            endcase
            repeat (PHASE_ITEMS) begin
                // now and then let the block run dry before the next item
                if ($urandom_range(0, 49) == 0)
                    drain();
                send_random_item();
            end
            drain();
        end

        // let any late or stray result item show up before the verdict
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatches == 0 && answers_owed == 0)
            $display("slot_allocator_reuse_delay_top_tb: PASS");
        else
            $display("slot_allocator_reuse_delay_top_tb: FAIL");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/sard_pkg.sv
hw/rtl/sard_ram.sv
hw/rtl/sard_slot_check.sv
hw/rtl/slot_allocator_reuse_delay_top.sv
sim/slot_table_checker.sv
sim/slot_allocator_reuse_delay_top_tb.sv
